/* rtl/core/timing_source_health_tracker_macros.svh */
// Assertion macros for the timing source health tracker.
// Each macro expects clk and rst_n in scope.
`ifndef TIMING_SOURCE_HEALTH_TRACKER_MACROS_SVH
`define TIMING_SOURCE_HEALTH_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TSHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsht: same-cycle check failed");

// Next-cycle implication.
`define TSHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsht: next-cycle check failed");

`else

`define TSHT_ASSERT_NOW(label, ante, cons)
`define TSHT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/tsht_pkg.sv */
`default_nettype none

package tsht_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_START    = 3'd1,
        OP_ANNOUNCE = 3'd2,
        OP_SYNC     = 3'd3,
        OP_TICK     = 3'd4
    } op_t;

    localparam logic [1:0] PORT_EVENT   = 2'd0;
    localparam logic [1:0] PORT_GENERAL = 2'd1;

    localparam logic [7:0] NO_SOURCE_LOG = 8'h7F;
    localparam logic [2:0] ANNOUNCE_MAX  = 3'd5;
    localparam logic [3:0] SYNC_MAX      = 4'd10;
    localparam logic [2:0] ANNOUNCE_GOOD = 3'd3;
    localparam logic [3:0] SYNC_GOOD     = 4'd6;

    // Drain period 2^(log+2) is reachable by an 8-bit counter only up to log 5;
    // below log -2 the period clamps to one tick.
    localparam logic signed [7:0] DRAIN_LOG_MAX = 8'sd5;
    localparam logic signed [7:0] DRAIN_LOG_MIN = -8'sd2;

    typedef struct packed {
        logic [2:0] announce_count;
        logic [3:0] sync_count;
        logic [3:0] followup_count;
        logic [7:0] announce_log;
        logic [7:0] sync_log;
        logic [7:0] announce_ticks;
        logic [7:0] sync_ticks;
        logic       health_flag;
        logic       two_step_flag;
    } tsht_state_t;

    localparam tsht_state_t STATE_RESET = '{
        announce_count: 3'd0,
        sync_count:     4'd0,
        followup_count: 4'd0,
        announce_log:   NO_SOURCE_LOG,
        sync_log:       NO_SOURCE_LOG,
        announce_ticks: 8'd0,
        sync_ticks:     8'd0,
        health_flag:    1'b0,
        two_step_flag:  1'b0
    };

    typedef struct packed {
        logic [7:0] ticks;
        logic       fire;
    } drain_t;

    function automatic tsht_state_t check_health(input tsht_state_t st);
        tsht_state_t r;
        r = st;
        if (st.sync_count == 4'd0 || (st.two_step_flag && st.followup_count == 4'd0))
        begin
            r.health_flag = 1'b0;
        end
        else if (st.announce_count > ANNOUNCE_GOOD && st.sync_count > SYNC_GOOD &&
                 (!st.two_step_flag || st.followup_count > SYNC_GOOD))
        begin
            r.health_flag = 1'b1;
        end
        return r;
    endfunction

    function automatic tsht_state_t feed_announce(input tsht_state_t st,
                                                  input logic [7:0] log_raw);
        tsht_state_t r;
        r = st;
        r.announce_log = log_raw;
        if (st.announce_count < ANNOUNCE_MAX)
        begin
            r.announce_count = st.announce_count + 3'd1;
        end
        return check_health(r);
    endfunction

    // Advance a drain counter by one tick and report an elapsed period.
    function automatic drain_t drain_step(input logic [7:0] ticks,
                                          input logic [7:0] log_raw);
        logic signed [7:0] lg;
        logic [2:0]        e;
        logic [7:0]        inc;
        drain_t            r;
        lg      = signed'(log_raw);
        inc     = ticks + 8'd1;
        r.ticks = inc;
        r.fire  = 1'b0;
        if (lg <= DRAIN_LOG_MAX)
        begin
            e = (lg < DRAIN_LOG_MIN) ? 3'd0 : 3'(lg - DRAIN_LOG_MIN);
            if (inc >= (8'd1 << e))
            begin
                r.ticks = 8'd0;
                r.fire  = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tsht_update.sv */
`default_nettype none

module tsht_update
    import tsht_pkg::*;
(
    input  tsht_state_t cur,
    input  logic [2:0]  op,
    input  logic [7:0]  log_interval,
    input  logic        two_step_bit,
    input  logic [1:0]  port_kind,
    output tsht_state_t nxt
);

    drain_t ann_drain;
    drain_t syn_drain;

    assign ann_drain = drain_step(cur.announce_ticks, cur.announce_log);
    assign syn_drain = drain_step(cur.sync_ticks, cur.sync_log);

    always_comb
    begin
        nxt = cur;
        unique case (op_t'(op))
            OP_CLEAR:
            begin
                nxt = STATE_RESET;
            end
            OP_START:
            begin
                nxt = feed_announce(STATE_RESET, log_interval);
            end
            OP_ANNOUNCE:
            begin
                nxt = feed_announce(cur, log_interval);
            end
            OP_SYNC:
            begin
                nxt.sync_log = log_interval;
                case (port_kind)
                    PORT_EVENT:
                    begin
                        nxt.two_step_flag = two_step_bit;
                        if (cur.sync_count < SYNC_MAX)
                        begin
                            nxt.sync_count = cur.sync_count + 4'd1;
                        end
                    end
                    PORT_GENERAL:
                    begin
                        if (cur.followup_count < SYNC_MAX)
                        begin
                            nxt.followup_count = cur.followup_count + 4'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                nxt = check_health(nxt);
            end
            OP_TICK:
            begin
                // no source yet: hold everything
                if (cur.announce_log != NO_SOURCE_LOG)
                begin
                    nxt.announce_ticks = ann_drain.ticks;
                    nxt.sync_ticks     = syn_drain.ticks;
                    if (ann_drain.fire && cur.announce_count != 3'd0)
                    begin
                        nxt.announce_count = cur.announce_count - 3'd1;
                    end
                    if (syn_drain.fire)
                    begin
                        if (cur.sync_count != 4'd0)
                        begin
                            nxt.sync_count = cur.sync_count - 4'd1;
                        end
                        if (cur.followup_count != 4'd0)
                        begin
                            nxt.followup_count = cur.followup_count - 4'd1;
                        end
                    end
                    nxt = check_health(nxt);
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/timing_source_health_tracker.sv */
// Path from input transfer to result transfer: input register, then result register.
// One event per cycle while out_stall is low; the state update is a read-modify-write.
// Each event yields exactly one result transfer, in order.
// Reset (rst_n low, asynchronous): counts and tick counters clear, logs go to the
// no-source marker, health and two-step flags clear, both stages empty.
`default_nettype none
`include "timing_source_health_tracker_macros.svh"

module timing_source_health_tracker
    import tsht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] op,
    input  logic [7:0] log_interval,
    input  logic       two_step_bit,
    input  logic [1:0] port_kind,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       healthy,
    output logic       valid_source,
    output logic [2:0] announce_level,
    output logic [3:0] sync_level,
    output logic [3:0] followup_level,
    output logic       two_step_mode
);

    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [7:0]  log_reg;
    logic        two_step_reg;
    logic [1:0]  port_reg;

    tsht_state_t state_reg;
    tsht_state_t state_next;

    logic        out_valid_reg;
    logic        healthy_reg;
    logic        valid_source_reg;
    logic [2:0]  announce_level_reg;
    logic [3:0]  sync_level_reg;
    logic [3:0]  followup_level_reg;
    logic        two_step_mode_reg;

    logic        out_free;
    logic        advance;
    logic        in_take;
    logic        next_valid_source;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    tsht_update u_update (
        .cur          (state_reg),
        .op           (op_reg),
        .log_interval (log_reg),
        .two_step_bit (two_step_reg),
        .port_kind    (port_reg),
        .nxt          (state_next)
    );

    assign next_valid_source = state_next.announce_log != NO_SOURCE_LOG;

    // Input stage: refill whenever the held event moves on or the stage is empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg       <= op;
            log_reg      <= log_interval;
            two_step_reg <= two_step_bit;
            port_reg     <= port_kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            healthy_reg        <= state_next.health_flag && next_valid_source;
            valid_source_reg   <= next_valid_source;
            announce_level_reg <= state_next.announce_count;
            sync_level_reg     <= state_next.sync_count;
            followup_level_reg <= state_next.followup_count;
            two_step_mode_reg  <= state_next.two_step_flag;
        end
    end

    assign out_valid      = out_valid_reg;
    assign healthy        = healthy_reg;
    assign valid_source   = valid_source_reg;
    assign announce_level = announce_level_reg;
    assign sync_level     = sync_level_reg;
    assign followup_level = followup_level_reg;
    assign two_step_mode  = two_step_mode_reg;

    `TSHT_ASSERT_NOW(a_health_needs_sync, state_reg.health_flag, state_reg.sync_count != 4'd0)
    `TSHT_ASSERT_NOW(a_healthy_has_source, out_valid_reg && healthy_reg, valid_source_reg)
    `TSHT_ASSERT_NEXT(a_held_event_kept, in_valid_reg && !out_free, in_valid_reg)
    `TSHT_ASSERT_NOW(a_counts_saturate, 1'b1,
        state_reg.announce_count <= ANNOUNCE_MAX && state_reg.sync_count <= SYNC_MAX)

endmodule

`default_nettype wire

/* dv/timing_source_health_tracker_tb.sv */
`timescale 1ns / 1ps

module timing_source_health_tracker_tb;
    import tsht_pkg::*;

    // Op codes with no function and ports outside event/general
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [1:0] PORT_OTHER     = 2'd2;
    localparam logic [1:0] PORT_SPARE     = 2'd3;
    localparam int         PHASE_ITEMS    = 163;
    localparam int         DIRECTED_ROWS  = 25;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] lg;
        logic       ts;
        logic [1:0] port;
    } tracker_input_t;

    typedef struct packed {
        logic       healthy;
        logic       valid_source;
        logic [2:0] announce_level;
        logic [3:0] sync_level;
        logic [3:0] followup_level;
        logic       two_step_mode;
    } tracker_status_t;

    typedef struct packed {
        tracker_input_t  stim;
        logic            typed;
        tracker_status_t status;
    } directed_row_t;

    logic       clk;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic [2:0] op             = OP_CLEAR;
    logic [7:0] log_interval   = 8'h00;
    logic       two_step_bit   = 1'b0;
    logic [1:0] port_kind      = PORT_EVENT;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic       healthy;
    logic       valid_source;
    logic [2:0] announce_level;
    logic [3:0] sync_level;
    logic [3:0] followup_level;
    logic       two_step_mode;

    timing_source_health_tracker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .log_interval   (log_interval),
        .two_step_bit   (two_step_bit),
        .port_kind      (port_kind),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .healthy        (healthy),
        .valid_source   (valid_source),
        .announce_level (announce_level),
        .sync_level     (sync_level),
        .followup_level (followup_level),
        .two_step_mode  (two_step_mode)
    );

    // Tracker state as predicted
    logic [2:0] ann_cnt;
    logic [3:0] syn_cnt;
    logic [3:0] fup_cnt;
    logic [7:0] ann_log;
    logic [7:0] syn_log;
    logic [7:0] ann_ticks;
    logic [7:0] syn_ticks;
    logic       health;
    logic       two_step;

    tracker_status_t status_q[$];
    int             errors         = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;

    // Random session context
    int         sess_left = 0;
    logic [7:0] sess_ann_lg;
    logic [7:0] sess_syn_lg;
    logic       sess_ts;

    directed_row_t rows [DIRECTED_ROWS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("timing_source_health_tracker_tb NOT OK");
        $finish;
    end

    task automatic clear_tracker();
        ann_cnt   = 3'd0;
        syn_cnt   = 4'd0;
        fup_cnt   = 4'd0;
        ann_log   = NO_SOURCE_LOG;
        syn_log   = NO_SOURCE_LOG;
        ann_ticks = 8'd0;
        syn_ticks = 8'd0;
        health    = 1'b0;
        two_step  = 1'b0;
    endtask

    task automatic refresh_health();
        if (syn_cnt == 4'd0 || (two_step && fup_cnt == 4'd0))
        begin
            health = 1'b0;
        end
        else if (ann_cnt > ANNOUNCE_GOOD && syn_cnt > SYNC_GOOD &&
                 (!two_step || fup_cnt > SYNC_GOOD))
        begin
            health = 1'b1;
        end
    endtask

    task automatic count_announce(input logic [7:0] lg);
        ann_log = lg;
        if (ann_cnt < ANNOUNCE_MAX)
        begin
            ann_cnt = ann_cnt + 3'd1;
        end
        refresh_health();
    endtask

    // Advance a tick counter; fire once 2^(lg+2) ticks have passed
    task automatic tick_drain(inout logic [7:0] ticks, input logic [7:0] lg,
                              output bit fired);
        logic signed [7:0] slg;
        int                e;
        slg = lg;
        e = slg + 2;
        if (e < 0)
        begin
            e = 0;
        end
        ticks = ticks + 8'd1;
        fired = 1'b0;
        if (e <= 7 && int'(ticks) >= (1 << e))
        begin
            ticks = 8'd0;
            fired = 1'b1;
        end
    endtask

    task automatic predict_status(input tracker_input_t it, output tracker_status_t st);
        bit fired;
        case (it.op)
            OP_CLEAR:
            begin
                clear_tracker();
            end
            OP_START:
            begin
                clear_tracker();
                count_announce(it.lg);
            end
            OP_ANNOUNCE:
            begin
                count_announce(it.lg);
            end
            OP_SYNC:
            begin
                syn_log = it.lg;
                if (it.port == PORT_EVENT)
                begin
                    two_step = it.ts;
                    if (syn_cnt < SYNC_MAX)
                    begin
                        syn_cnt = syn_cnt + 4'd1;
                    end
                end
                else if (it.port == PORT_GENERAL)
                begin
                    if (fup_cnt < SYNC_MAX)
                    begin
                        fup_cnt = fup_cnt + 4'd1;
                    end
                end
                refresh_health();
            end
            OP_TICK:
            begin
                // No source: tick is ignored, health held
                if (ann_log != NO_SOURCE_LOG)
                begin
                    tick_drain(ann_ticks, ann_log, fired);
                    if (fired && ann_cnt > 3'd0)
                    begin
                        ann_cnt = ann_cnt - 3'd1;
                    end
                    tick_drain(syn_ticks, syn_log, fired);
                    if (fired)
                    begin
                        if (syn_cnt > 4'd0)
                        begin
                            syn_cnt = syn_cnt - 4'd1;
                        end
                        if (fup_cnt > 4'd0)
                        begin
                            fup_cnt = fup_cnt - 4'd1;
                        end
                    end
                    refresh_health();
                end
            end
            default:
            begin
            end
        endcase
        st.healthy        = health && (ann_log != NO_SOURCE_LOG);
        st.valid_source   = (ann_log != NO_SOURCE_LOG);
        st.announce_level = ann_cnt;
        st.sync_level     = syn_cnt;
        st.followup_level = fup_cnt;
        st.two_step_mode  = two_step;
    endtask

    function automatic tracker_status_t pack_status(logic h, logic v, logic [2:0] a,
                                                    logic [3:0] s, logic [3:0] f, logic t);
        tracker_status_t st;
        st.healthy        = h;
        st.valid_source   = v;
        st.announce_level = a;
        st.sync_level     = s;
        st.followup_level = f;
        st.two_step_mode  = t;
        return st;
    endfunction

    function automatic directed_row_t row(logic [2:0] o, logic [7:0] lg, logic ts,
                                          logic [1:0] port, logic typed,
                                          tracker_status_t st);
        directed_row_t r;
        r.stim.op   = o;
        r.stim.lg   = lg;
        r.stim.ts   = ts;
        r.stim.port = port;
        r.typed     = typed;
        r.status    = st;
        return r;
    endfunction

    // Mostly short intervals so drains fire; some beyond the counter's reach
    function automatic logic [7:0] pick_log();
        int r;
        r = $urandom_range(99);
        if (r < 80)
        begin
            return 8'($urandom_range(8) - 3);
        end
        else if (r < 90)
        begin
            return 8'($urandom_range(10, 6));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic next_random_item(output tracker_input_t it);
        int r;
        it.op   = OP_SYNC;
        it.lg   = sess_syn_lg;
        it.ts   = sess_ts;
        it.port = PORT_EVENT;
        if (sess_left == 0)
        begin
            sess_left   = $urandom_range(60, 10);
            sess_ann_lg = pick_log();
            sess_syn_lg = pick_log();
            sess_ts     = 1'($urandom_range(1));
            it.op       = OP_START;
            it.lg       = sess_ann_lg;
            it.ts       = 1'($urandom_range(1));
            it.port     = 2'($urandom_range(3));
            return;
        end
        sess_left = sess_left - 1;
        r = $urandom_range(99);
        if (r < 5)
        begin
            it.op   = 3'($urandom_range(7));
            it.lg   = 8'($urandom_range(255));
            it.ts   = 1'($urandom_range(1));
            it.port = 2'($urandom_range(3));
        end
        else if (r < 8)
        begin
            // Change sync interval mid-session, often to a short one
            sess_syn_lg = pick_log();
            it.lg       = sess_syn_lg;
        end
        else if (r < 33)
        begin
            it.op = OP_ANNOUNCE;
            it.lg = sess_ann_lg;
            it.ts = 1'($urandom_range(1));
        end
        else if (r < 70)
        begin
            if ($urandom_range(99) < 5)
            begin
                it.port = 2'($urandom_range(3, 2));
            end
            else if (sess_ts && $urandom_range(1))
            begin
                it.port = PORT_GENERAL;
            end
            if ($urandom_range(99) < 3)
            begin
                it.ts = ~sess_ts;
            end
        end
        else
        begin
            it.op = OP_TICK;
            it.lg = 8'($urandom_range(255));
        end
    endtask

    task automatic send_item(input tracker_input_t it, input bit typed,
                             input tracker_status_t typed_st);
        tracker_status_t st;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= it.op;
        log_interval <= it.lg;
        two_step_bit <= it.ts;
        port_kind    <= it.port;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_status(it, st);
        status_q.push_back(typed ? typed_st : st);
    endtask

    // Hold off the sender until every result is back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (status_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic compare_status(input tracker_status_t exp_st, input tracker_status_t got);
        if (got.healthy !== exp_st.healthy)
        begin
            $error("healthy: expected %0d, got %0d", exp_st.healthy, got.healthy);
            errors++;
        end
        if (got.valid_source !== exp_st.valid_source)
        begin
            $error("valid_source: expected %0d, got %0d", exp_st.valid_source,
                   got.valid_source);
            errors++;
        end
        if (got.announce_level !== exp_st.announce_level)
        begin
            $error("announce_level: expected %0d, got %0d", exp_st.announce_level,
                   got.announce_level);
            errors++;
        end
        if (got.sync_level !== exp_st.sync_level)
        begin
            $error("sync_level: expected %0d, got %0d", exp_st.sync_level, got.sync_level);
            errors++;
        end
        if (got.followup_level !== exp_st.followup_level)
        begin
            $error("followup_level: expected %0d, got %0d", exp_st.followup_level,
                   got.followup_level);
            errors++;
        end
        if (got.two_step_mode !== exp_st.two_step_mode)
        begin
            $error("two_step_mode: expected %0d, got %0d", exp_st.two_step_mode,
                   got.two_step_mode);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                compare_status(status_q.pop_front(),
                               pack_status(healthy, valid_source, announce_level,
                                           sync_level, followup_level, two_step_mode));
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        tracker_input_t it;
        int             n;
        clear_tracker();

        n = 0;
        rows[n++] = row(OP_TICK, 8'h00, 1'b0, PORT_EVENT, 1'b1, pack_status(0, 0, 0, 0, 0, 0));
        rows[n++] = row(OP_SYNC, 8'h00, 1'b1, PORT_EVENT, 1'b1, pack_status(0, 0, 0, 1, 0, 1));
        rows[n++] = row(OP_SPARE_FIRST, 8'hFF, 1'b1, PORT_SPARE, 1'b1,
                        pack_status(0, 0, 0, 1, 0, 1));
        rows[n++] = row(OP_SPARE_LAST, 8'h55, 1'b0, PORT_OTHER, 1'b0, '0);
        rows[n++] = row(OP_CLEAR, 8'hAA, 1'b1, PORT_SPARE, 1'b1, pack_status(0, 0, 0, 0, 0, 0));
        rows[n++] = row(OP_START, 8'h80, 1'b0, PORT_EVENT, 1'b1, pack_status(0, 1, 1, 0, 0, 0));
        repeat (4)
        begin
            rows[n++] = row(OP_ANNOUNCE, 8'h80, 1'b0, PORT_EVENT, 1'b0, '0);
        end
        // Announce with the no-source marker drops the source, count saturated
        rows[n++] = row(OP_ANNOUNCE, NO_SOURCE_LOG, 1'b0, PORT_EVENT, 1'b1,
                        pack_status(0, 0, 5, 0, 0, 0));
        rows[n++] = row(OP_TICK, 8'h01, 1'b0, PORT_EVENT, 1'b1, pack_status(0, 0, 5, 0, 0, 0));
        rows[n++] = row(OP_ANNOUNCE, 8'h05, 1'b1, PORT_GENERAL, 1'b0, '0);
        rows[n++] = row(OP_SYNC, NO_SOURCE_LOG, 1'b1, PORT_OTHER, 1'b0, '0);
        rows[n++] = row(OP_SYNC, 8'hFE, 1'b1, PORT_SPARE, 1'b0, '0);
        repeat (7)
        begin
            rows[n++] = row(OP_SYNC, 8'hFE, 1'b0, PORT_EVENT, 1'b0, '0);
        end
        rows[n++] = row(OP_TICK, 8'h00, 1'b0, PORT_EVENT, 1'b0, '0);
        rows[n++] = row(OP_SYNC, NO_SOURCE_LOG, 1'b0, PORT_GENERAL, 1'b0, '0);
        rows[n++] = row(OP_TICK, 8'h00, 1'b0, PORT_EVENT, 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < n; i++)
        begin
            send_item(rows[i].stim, rows[i].typed, rows[i].status);
        end
        wait_for_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                default:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                next_random_item(it);
                send_item(it, 1'b0, '0);
            end
            wait_for_results();
        end

        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        if (errors == 0 && status_q.size() == 0)
        begin
            $display("timing_source_health_tracker_tb OK");
        end
        else
        begin
            $display("timing_source_health_tracker_tb NOT OK");
        end
        $finish;
    end

endmodule
